/* hw/rtl/blr_pkg.sv */
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int CHAR_BITS      = 8;
  localparam int QUEUE_DEPTH    = 2;

  // error term width: holds values in (-2*major, 2*minor]
  function automatic int err_width(input int coord_bits);
    return coord_bits + 2;
  endfunction

  // packed command word:
  // {steep, step_neg, m0, m_end, n0, two_minor, d0, diag, fill_char}
  function automatic int cmd_width(input int coord_bits);
    return 2 + 3 * coord_bits + (coord_bits + 1) + 2 * err_width(coord_bits) + CHAR_BITS;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/blr_front.sv */
`default_nettype none

module blr_front
  import blr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW        = err_width(COORD_BITS),
  localparam int CMD_W     = cmd_width(COORD_BITS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [CHAR_BITS-1:0]  fill_char,
  output logic                       cmd_valid,
  input  wire logic                  cmd_ready,
  output logic [CMD_W-1:0]           cmd_data
);

  logic                  hold_valid;
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [CHAR_BITS-1:0]  ch;

  logic [COORD_BITS-1:0] adx, ady, major, minor;
  logic [COORD_BITS-1:0] m0, m_end, n0, n_end;
  logic                  steep, swap, step_neg;
  logic [COORD_BITS:0]   two_minor;
  logic [DW-1:0]         d0, diag;

  assign in_ready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax <= start_x;
      ay <= start_y;
      bx <= end_x;
      by <= end_y;
      ch <= fill_char;
    end
  end

  // classify and order endpoints so the major axis rises
  always_comb begin
    adx   = (bx > ax) ? bx - ax : ax - bx;
    ady   = (by > ay) ? by - ay : ay - by;
    steep = !(ady < adx);
    swap  = steep ? (ay > by) : (ax > bx);
    major = steep ? ady : adx;
    minor = steep ? adx : ady;
    if (steep) begin
      m0    = swap ? by : ay;
      m_end = swap ? ay : by;
      n0    = swap ? bx : ax;
      n_end = swap ? ax : bx;
    end else begin
      m0    = swap ? bx : ax;
      m_end = swap ? ax : bx;
      n0    = swap ? by : ay;
      n_end = swap ? ay : by;
    end
    step_neg  = n_end < n0;
    two_minor = {minor, 1'b0};
    d0        = {1'b0, minor, 1'b0} - {2'b00, major};
    diag      = {1'b0, minor, 1'b0} - {1'b0, major, 1'b0};
    cmd_data  = {steep, step_neg, m0, m_end, n0, two_minor, d0, diag, ch};
  end

endmodule

`default_nettype wire

/* hw/rtl/blr_queue.sv */
`default_nettype none

module blr_queue
  import blr_pkg::*;
#(
  parameter int WIDTH  = cmd_width(COORD_BITS_DEF),
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push, pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not track push");

endmodule

`default_nettype wire

/* hw/rtl/blr_walker.sv */
`default_nettype none

module blr_walker
  import blr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW        = err_width(COORD_BITS),
  localparam int CMD_W     = cmd_width(COORD_BITS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire logic [CMD_W-1:0]      cmd_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic [CHAR_BITS-1:0]       pixel_char,
  output logic                       last_pixel
);

  logic                  busy;
  logic                  steep, step_neg;
  logic [COORD_BITS-1:0] m, m_end, n;
  logic [COORD_BITS:0]   two_minor;
  logic signed [DW-1:0]  d, diag;
  logic [CHAR_BITS-1:0]  ch;

  logic                  c_steep, c_step_neg;
  logic [COORD_BITS-1:0] c_m0, c_m_end, c_n0;
  logic [COORD_BITS:0]   c_two_minor;
  logic [DW-1:0]         c_d0, c_diag;
  logic [CHAR_BITS-1:0]  c_ch;

  logic                  load, adv, at_end;

  assign {c_steep, c_step_neg, c_m0, c_m_end, c_n0, c_two_minor, c_d0, c_diag, c_ch} = cmd_data;

  assign cmd_ready = !busy;
  assign load      = cmd_valid && !busy;
  assign adv       = busy && (!out_valid || out_ready);
  assign at_end    = m == m_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (adv && at_end) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      steep     <= c_steep;
      step_neg  <= c_step_neg;
      m         <= c_m0;
      m_end     <= c_m_end;
      n         <= c_n0;
      two_minor <= c_two_minor;
      d         <= c_d0;
      diag      <= c_diag;
      ch        <= c_ch;
    end else if (adv) begin
      pixel_x    <= steep ? n : m;
      pixel_y    <= steep ? m : n;
      pixel_char <= ch;
      last_pixel <= at_end;
      m          <= m + 1'b1;
      if (d > 0) begin
        n <= step_neg ? n - 1'b1 : n + 1'b1;
        d <= d + diag;
      end else begin
        d <= d + $signed({1'b0, two_minor});
      end
    end
  end

  a_major_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> m <= m_end)
    else $error("major coordinate ran past line end");

  a_end_releases: assert property (@(posedge clk) disable iff (rst)
    adv && at_end |=> !busy && out_valid && last_pixel)
    else $error("final pixel did not close the line");

endmodule

`default_nettype wire

/* hw/rtl/bresenham_line_rasterizer.sv */
// A request is registered in the front end and then written into the command queue;
// the walker loads it and registers each pixel word. Throughput: one pixel per cycle
//   while out_ready is high; a line of |major delta| + 1 pixels follows each command load.
// A two-entry command queue lets the next request be classified during a walk.
// Reset (rst, synchronous): empties the queue and drops any line in progress.
`default_nettype none

module bresenham_line_rasterizer
  import blr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [CHAR_BITS-1:0]  fill_char,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic [CHAR_BITS-1:0]       pixel_char,
  output logic                       last_pixel
);

  localparam int CMD_W = cmd_width(COORD_BITS);

  logic             f_valid, f_ready;
  logic [CMD_W-1:0] f_data;
  logic             q_valid, q_ready;
  logic [CMD_W-1:0] q_data;

  blr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .fill_char (fill_char),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  blr_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  blr_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_data   (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_char (pixel_char),
    .last_pixel (last_pixel)
  );

endmodule

`default_nettype wire
